### hw/rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg: shared types, constants and arithmetic helpers
// Word format, configuration layout, datapath commands and the saturating
// operations used by the mass-spring-damper stepper.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int CFG_W      = 23;
    localparam int INIT_W     = 21;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 32;

    // Width of a scaled product magnitude and of the divider quotient.
    localparam int SM_W       = 2 * WORD_W - FRAC_W;
    localparam int PROD_W     = 2 * WORD_W;
    // The divider retires two quotient bits per cycle.
    localparam int DIV_STEPS  = SM_W / 2;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [IDX_W-1:0] REG_MASS     = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_SPRING   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_DAMPING  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_INIT_POS = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_INIT_VEL = IDX_W'(4);

    localparam logic [CFG_W-1:0]  RST_MASS     = CFG_W'(655360);
    localparam logic [CFG_W-1:0]  RST_SPRING   = CFG_W'(1310720);
    localparam logic [CFG_W-1:0]  RST_DAMPING  = CFG_W'(1966080);
    localparam logic [INIT_W-1:0] RST_INIT_POS = '0;
    localparam logic [INIT_W-1:0] RST_INIT_VEL = '0;

    localparam logic [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [SM_W-1:0]   POS_LIM = {{(SM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic [SM_W-1:0]   NEG_LIM = POS_LIM + SM_W'(1);

    typedef struct packed {
        logic [CFG_W-1:0]  mass;
        logic [CFG_W-1:0]  spring;
        logic [CFG_W-1:0]  damping;
        logic [INIT_W-1:0] init_pos;
        logic [INIT_W-1:0] init_vel;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_IDLE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_MUL_D    = 4'd2,
        OP_MUL_K    = 4'd3,
        OP_SUB_K    = 4'd4,
        OP_DIV_LD   = 4'd5,
        OP_DIV_STEP = 4'd6,
        OP_DIV_END  = 4'd7,
        OP_MUL_A    = 4'd8,
        OP_ADD_V    = 4'd9,
        OP_MUL_V    = 4'd10,
        OP_ADD_P    = 4'd11,
        OP_PUBLISH  = 4'd12
    } t_op;

    typedef struct packed {
        logic div_last;
    } t_dp_stat;

    typedef struct packed {
        logic [WORD_W-1:0] v;
        logic              sat;
    } t_sres;

    function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] a);
        return a[WORD_W-1] ? (~a + 1'b1) : a;
    endfunction

    // Floor of the mean of two signed words; never overflows.
    function automatic logic [WORD_W-1:0] avg_floor(input logic [WORD_W-1:0] a,
                                                    input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        return s[WORD_W:1];
    endfunction

    // Apply a sign to a magnitude and clip to the word range.
    function automatic t_sres sat_mag(input logic [SM_W-1:0] m, input logic neg);
        t_sres r;
        r.sat = 1'b0;
        if (neg) begin
            if (m > NEG_LIM) begin
                r.v   = WMIN;
                r.sat = 1'b1;
            end else begin
                r.v = ~m[WORD_W-1:0] + 1'b1;
            end
        end else begin
            if (m > POS_LIM) begin
                r.v   = WMAX;
                r.sat = 1'b1;
            end else begin
                r.v = m[WORD_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic t_sres sat_add(input logic [WORD_W-1:0] a,
                                      input logic [WORD_W-1:0] b);
        t_sres r;
        logic [WORD_W:0] s;
        s     = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        r.sat = s[WORD_W] != s[WORD_W-1];
        r.v   = r.sat ? (s[WORD_W] ? WMIN : WMAX) : s[WORD_W-1:0];
        return r;
    endfunction

    function automatic t_sres sat_sub(input logic [WORD_W-1:0] a,
                                      input logic [WORD_W-1:0] b);
        t_sres r;
        logic [WORD_W:0] s;
        s     = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        r.sat = s[WORD_W] != s[WORD_W-1];
        r.v   = r.sat ? (s[WORD_W] ? WMIN : WMAX) : s[WORD_W-1:0];
        return r;
    endfunction

endpackage

### hw/rtl/msd_in_if.sv
// ----------------------------------------------------------------------------
// msd_in_if: input item channel
// One word per step: restart command, applied force and sample time.
// ----------------------------------------------------------------------------
interface msd_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [msd_pkg::WORD_W-1:0]   force_req;
    logic        [msd_pkg::WORD_W-1:0]   sample_time;

    modport source (output valid, cmd, force_req, sample_time, input ready);
    modport sink   (input valid, cmd, force_req, sample_time, output ready);
endinterface

### hw/rtl/msd_out_if.sv
// ----------------------------------------------------------------------------
// msd_out_if: result channel
// One word per step: new position, new velocity, acceleration and clip flag.
// ----------------------------------------------------------------------------
interface msd_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [msd_pkg::WORD_W-1:0]   position;
    logic signed [msd_pkg::WORD_W-1:0]   velocity;
    logic signed [msd_pkg::WORD_W-1:0]   acceleration;
    logic                                saturated;

    modport source (output valid, position, velocity, acceleration, saturated,
                    input ready);
    modport sink   (input valid, position, velocity, acceleration, saturated,
                    output ready);
endinterface

### hw/rtl/msd_cfg_if.sv
// ----------------------------------------------------------------------------
// msd_cfg_if: configuration write channel
// Register index and write data, one register per word.
// ----------------------------------------------------------------------------
interface msd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [msd_pkg::IDX_W-1:0]           index;
    logic [msd_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/mass_spring_damper_step.sv
// ----------------------------------------------------------------------------
// mass_spring_damper_step: fixed-point mass-spring-damper stepper
// Each step runs, in order: the accept, two shared-multiplier passes with
// their saturating subtracts, the divider load, a radix-4 serial divide by
// the mass, the divider unload, two more multiplier passes with saturating
// adds, and the publish. The next input word is taken only after the result
// of the last one is published, so one step is in flight at a time.
// Reset (synchronous, active low) zeroes position, velocity and the history,
// loads the configuration defaults and leaves both channels empty.
// ----------------------------------------------------------------------------
module mass_spring_damper_step (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msd_in_if.sink     i_item,
    msd_out_if.source  o_result,
    msd_cfg_if.sink    i_cfg
);

    // The configuration block is a plain register file. Writes are always
    // accepted and are expected only while no step is in flight.
    msd_pkg::t_cfg     cfg;
    msd_pkg::t_op      op;
    msd_pkg::t_dp_stat stat;

    msd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .o_wr_ready (i_cfg.ready),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    // The controller accepts one input word at a time. While a finished
    // result still waits in the output register, the next word is taken in
    // and worked on; only the final publish step waits for the output slot.
    msd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_op        (op),
        .i_stat      (stat)
    );

    // The datapath computes the damping and spring forces on one shared
    // multiplier, divides the net force by the mass bit-serially, and then
    // integrates velocity and position with the trapezoid rule over the
    // elapsed sample time. Every intermediate result saturates to the word
    // range, and any clip is reported with the result.
    msd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_stat         (stat),
        .i_cfg          (cfg),
        .i_cmd          (i_item.cmd),
        .i_force_req    (i_item.force_req),
        .i_sample_time  (i_item.sample_time),
        .o_position     (o_result.position),
        .o_velocity     (o_result.velocity),
        .o_acceleration (o_result.acceleration),
        .o_saturated    (o_result.saturated)
    );

endmodule

### hw/rtl/msd_cfg.sv
// ----------------------------------------------------------------------------
// msd_cfg: configuration register file
// Holds mass, stiffness, damping and the restart position and velocity.
// ----------------------------------------------------------------------------
module msd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_valid,
    output logic                           o_wr_ready,
    input  logic [msd_pkg::IDX_W-1:0]      i_wr_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0] i_wr_data,
    output msd_pkg::t_cfg                  o_cfg
);

    msd_pkg::t_cfg r_cfg;
    msd_pkg::t_cfg n_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            case (i_wr_index)
                msd_pkg::REG_MASS:     n_cfg.mass     = i_wr_data[msd_pkg::CFG_W-1:0];
                msd_pkg::REG_SPRING:   n_cfg.spring   = i_wr_data[msd_pkg::CFG_W-1:0];
                msd_pkg::REG_DAMPING:  n_cfg.damping  = i_wr_data[msd_pkg::CFG_W-1:0];
                msd_pkg::REG_INIT_POS: n_cfg.init_pos = i_wr_data[msd_pkg::INIT_W-1:0];
                msd_pkg::REG_INIT_VEL: n_cfg.init_vel = i_wr_data[msd_pkg::INIT_W-1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mass     <= msd_pkg::RST_MASS;
            r_cfg.spring   <= msd_pkg::RST_SPRING;
            r_cfg.damping  <= msd_pkg::RST_DAMPING;
            r_cfg.init_pos <= msd_pkg::RST_INIT_POS;
            r_cfg.init_vel <= msd_pkg::RST_INIT_VEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### hw/rtl/msd_datapath.sv
// ----------------------------------------------------------------------------
// msd_datapath: state registers, shared multiplier and serial divider
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
module msd_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  msd_pkg::t_op                      i_op,
    output msd_pkg::t_dp_stat                 o_stat,
    input  msd_pkg::t_cfg                     i_cfg,
    input  logic                              i_cmd,
    input  logic signed [msd_pkg::WORD_W-1:0] i_force_req,
    input  logic        [msd_pkg::WORD_W-1:0] i_sample_time,
    output logic signed [msd_pkg::WORD_W-1:0] o_position,
    output logic signed [msd_pkg::WORD_W-1:0] o_velocity,
    output logic signed [msd_pkg::WORD_W-1:0] o_acceleration,
    output logic                              o_saturated
);

    localparam int W = msd_pkg::WORD_W;

    // Architectural state.
    logic [W-1:0] r_pos, r_vel, r_pacc, r_pvel, r_ptime;
    // Working registers of one step.
    logic [W-1:0]                  r_force, r_time, r_num, r_acc;
    logic [W:0]                    r_dt;
    logic [msd_pkg::PROD_W-1:0]    r_prod;
    logic                          r_pneg;
    logic [msd_pkg::CFG_W-1:0]     r_rem;
    logic [msd_pkg::SM_W-1:0]      r_quo;
    logic                          r_dneg;
    logic [msd_pkg::CNT_W-1:0]     r_cnt;
    logic                          r_sat;
    logic [W-1:0]                  r_o_pos, r_o_vel, r_o_acc;
    logic                          r_o_sat;

    logic [W-1:0]              mul_a, mul_b, avg_acc, avg_vel, dt_mag, ld_pos, ld_vel;
    logic [W-1:0]              base_time;
    logic [W:0]                dt_neg;
    logic                      mul_neg;
    logic [msd_pkg::CFG_W-1:0] divisor, n_rem;
    logic [msd_pkg::SM_W-1:0]  n_quo;
    logic [msd_pkg::CFG_W:0]   trial;
    msd_pkg::t_sres            scaled, num_k, num_s, acc_s, vel_s, pos_s;

    assign avg_acc = msd_pkg::avg_floor(r_pacc, r_acc);
    assign avg_vel = msd_pkg::avg_floor(r_pvel, r_vel);
    assign dt_neg  = ~r_dt + 1'b1;
    assign dt_mag  = r_dt[W] ? dt_neg[W-1:0] : r_dt[W-1:0];
    assign ld_pos  = {{(W-msd_pkg::INIT_W){i_cfg.init_pos[msd_pkg::INIT_W-1]}}, i_cfg.init_pos};
    assign ld_vel  = {{(W-msd_pkg::INIT_W){i_cfg.init_vel[msd_pkg::INIT_W-1]}}, i_cfg.init_vel};

    // A restart measures the elapsed time from zero.
    assign base_time = i_cmd ? W'(0) : r_ptime;

    // A zero mass acts as one LSB.
    assign divisor = (i_cfg.mass == '0) ? msd_pkg::CFG_W'(1) : i_cfg.mass;

    assign scaled = msd_pkg::sat_mag(r_prod[msd_pkg::PROD_W-1:msd_pkg::FRAC_W], r_pneg);
    assign num_k  = msd_pkg::sat_sub(r_force, scaled.v);
    assign num_s  = msd_pkg::sat_sub(r_num, scaled.v);
    assign acc_s  = msd_pkg::sat_mag(r_quo, r_dneg);
    assign vel_s  = msd_pkg::sat_add(r_vel, scaled.v);
    assign pos_s  = msd_pkg::sat_add(r_pos, scaled.v);

    assign o_stat.div_last = r_cnt == msd_pkg::CNT_W'(msd_pkg::DIV_STEPS - 1);

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (i_op)
            msd_pkg::OP_MUL_D: begin
                mul_a   = W'(i_cfg.damping);
                mul_b   = msd_pkg::mag(r_vel);
                mul_neg = r_vel[W-1];
            end
            msd_pkg::OP_MUL_K: begin
                mul_a   = W'(i_cfg.spring);
                mul_b   = msd_pkg::mag(r_pos);
                mul_neg = r_pos[W-1];
            end
            msd_pkg::OP_MUL_A: begin
                mul_a   = dt_mag;
                mul_b   = msd_pkg::mag(avg_acc);
                mul_neg = r_dt[W] ^ avg_acc[W-1];
            end
            msd_pkg::OP_MUL_V: begin
                mul_a   = dt_mag;
                mul_b   = msd_pkg::mag(avg_vel);
                mul_neg = r_dt[W] ^ avg_vel[W-1];
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    // Two restoring-division steps per cycle.
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int i = 0; i < 2; i++) begin
            trial = {n_rem, n_quo[msd_pkg::SM_W-1]};
            n_quo = {n_quo[msd_pkg::SM_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                n_rem    = msd_pkg::CFG_W'(trial - {1'b0, divisor});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[msd_pkg::CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_vel   <= '0;
            r_pacc  <= '0;
            r_pvel  <= '0;
            r_ptime <= '0;
            r_cnt   <= '0;
        end else begin
            case (i_op)
                msd_pkg::OP_LOAD: begin
                    if (i_cmd) begin
                        r_pos   <= ld_pos;
                        r_vel   <= ld_vel;
                        r_pacc  <= '0;
                        r_pvel  <= '0;
                        r_ptime <= '0;
                    end
                end
                msd_pkg::OP_DIV_LD:   r_cnt <= '0;
                msd_pkg::OP_DIV_STEP: r_cnt <= r_cnt + 1'b1;
                msd_pkg::OP_ADD_V: begin
                    r_vel  <= vel_s.v;
                    r_pacc <= r_acc;
                end
                msd_pkg::OP_ADD_P: begin
                    r_pos   <= pos_s.v;
                    r_pvel  <= r_vel;
                    r_ptime <= r_time;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_pneg <= mul_neg;
        case (i_op)
            msd_pkg::OP_LOAD: begin
                r_force <= i_force_req;
                r_time  <= i_sample_time;
                r_dt    <= {1'b0, i_sample_time} - {1'b0, base_time};
                r_sat   <= 1'b0;
            end
            msd_pkg::OP_MUL_K: begin
                r_num <= num_k.v;
                r_sat <= r_sat | num_k.sat | scaled.sat;
            end
            msd_pkg::OP_SUB_K: begin
                r_num <= num_s.v;
                r_sat <= r_sat | num_s.sat | scaled.sat;
            end
            msd_pkg::OP_DIV_LD: begin
                r_rem  <= '0;
                r_quo  <= {msd_pkg::mag(r_num), {msd_pkg::FRAC_W{1'b0}}};
                r_dneg <= r_num[W-1];
            end
            msd_pkg::OP_DIV_STEP: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
            end
            msd_pkg::OP_DIV_END: begin
                r_acc <= acc_s.v;
                r_sat <= r_sat | acc_s.sat;
            end
            msd_pkg::OP_ADD_V: r_sat <= r_sat | vel_s.sat | scaled.sat;
            msd_pkg::OP_ADD_P: r_sat <= r_sat | pos_s.sat | scaled.sat;
            msd_pkg::OP_PUBLISH: begin
                r_o_pos <= r_pos;
                r_o_vel <= r_vel;
                r_o_acc <= r_acc;
                r_o_sat <= r_sat;
            end
            default: r_sat <= r_sat;
        endcase
    end

    assign o_position     = r_o_pos;
    assign o_velocity     = r_o_vel;
    assign o_acceleration = r_o_acc;
    assign o_saturated    = r_o_sat;

endmodule

### hw/rtl/msd_ctrl.sv
// ----------------------------------------------------------------------------
// msd_ctrl: step sequencer
// Walks one step through multiply, divide and integrate commands and owns
// the handshakes of both channels.
// ----------------------------------------------------------------------------
module msd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output msd_pkg::t_op      o_op,
    input  msd_pkg::t_dp_stat i_stat
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_MUL_D   = 12'b0000_0000_0010,
        S_MUL_K   = 12'b0000_0000_0100,
        S_SUB_K   = 12'b0000_0000_1000,
        S_DIV_LD  = 12'b0000_0001_0000,
        S_DIV     = 12'b0000_0010_0000,
        S_DIV_END = 12'b0000_0100_0000,
        S_MUL_A   = 12'b0000_1000_0000,
        S_ADD_V   = 12'b0001_0000_0000,
        S_MUL_V   = 12'b0010_0000_0000,
        S_ADD_P   = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   publish;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_vld;
    assign publish     = (r_state == S_DONE) && (!r_out_vld || i_out_ready);

    always_comb begin
        n_state = r_state;
        o_op    = msd_pkg::OP_IDLE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = msd_pkg::OP_LOAD;
                    n_state = S_MUL_D;
                end
            end
            S_MUL_D: begin
                o_op    = msd_pkg::OP_MUL_D;
                n_state = S_MUL_K;
            end
            S_MUL_K: begin
                o_op    = msd_pkg::OP_MUL_K;
                n_state = S_SUB_K;
            end
            S_SUB_K: begin
                o_op    = msd_pkg::OP_SUB_K;
                n_state = S_DIV_LD;
            end
            S_DIV_LD: begin
                o_op    = msd_pkg::OP_DIV_LD;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_op = msd_pkg::OP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                o_op    = msd_pkg::OP_DIV_END;
                n_state = S_MUL_A;
            end
            S_MUL_A: begin
                o_op    = msd_pkg::OP_MUL_A;
                n_state = S_ADD_V;
            end
            S_ADD_V: begin
                o_op    = msd_pkg::OP_ADD_V;
                n_state = S_MUL_V;
            end
            S_MUL_V: begin
                o_op    = msd_pkg::OP_MUL_V;
                n_state = S_ADD_P;
            end
            S_ADD_P: begin
                o_op    = msd_pkg::OP_ADD_P;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (publish) begin
                    o_op    = msd_pkg::OP_PUBLISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                o_op    = msd_pkg::OP_IDLE;
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (publish) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

### hw/rtl/msd_checker.sv
// ----------------------------------------------------------------------------
// msd_checker: port-level checks for the stepper
// Watches the handshakes at the top level and the pacing of results.
// ----------------------------------------------------------------------------
module msd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [msd_pkg::WORD_W-1:0]   i_position,
    input logic [msd_pkg::WORD_W-1:0]   i_velocity,
    input logic [msd_pkg::WORD_W-1:0]   i_acceleration,
    input logic                         i_saturated
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_position) && $stable(i_velocity)
            && $stable(i_acceleration) && $stable(i_saturated))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("second word taken while a step is in progress");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(in_acc, 1) && !$past(in_acc, 2))
        else $error("result appeared too soon after an input word");

endmodule

bind mass_spring_damper_step msd_checker u_msd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_position     (o_result.position),
    .i_velocity     (o_result.velocity),
    .i_acceleration (o_result.acceleration),
    .i_saturated    (o_result.saturated)
);

### verif/tb_mass_spring_damper_step.sv
// ----------------------------------------------------------------------------
// tb_mass_spring_damper_step: self-checking bench for the stepper
// Drives force and time words into the block, predicts every result word from
// a fixed-point model of the trapezoidal integrator, and compares position,
// velocity, acceleration and the clip flag. Both channels idle at random, and
// the parameters are rewritten between phases while the block is empty.
// ----------------------------------------------------------------------------
module tb_mass_spring_damper_step;

    // Limits of a signed result word, held wide so that sums cannot wrap.
    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -64'sd2147483648;

    typedef struct packed {
        logic [msd_pkg::WORD_W-1:0] position;
        logic [msd_pkg::WORD_W-1:0] velocity;
        logic [msd_pkg::WORD_W-1:0] acceleration;
        logic                       saturated;
    } t_step;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the parameters and of the motion
    // state, works out the result of every accepted input word, and queues it
    // until the matching result word arrives.
    // ------------------------------------------------------------------------
    class msd_scoreboard;
        t_step        expected_q[$];
        int unsigned  n_errors;

        logic [msd_pkg::CFG_W-1:0] mass, spring, damping;
        longint                    init_pos, init_vel;

        longint                     pos, vel, prev_acc, prev_vel;
        logic [msd_pkg::WORD_W-1:0] prev_t;
        bit                         clipped;

        function new();
            mass     = msd_pkg::RST_MASS;
            spring   = msd_pkg::RST_SPRING;
            damping  = msd_pkg::RST_DAMPING;
            init_pos = 0;
            init_vel = 0;
            pos      = 0;
            vel      = 0;
            prev_acc = 0;
            prev_vel = 0;
            prev_t   = '0;
            n_errors = 0;
        endfunction

        function void write_reg(logic [msd_pkg::IDX_W-1:0] idx,
                                logic [msd_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                msd_pkg::REG_MASS:     mass     = value[msd_pkg::CFG_W-1:0];
                msd_pkg::REG_SPRING:   spring   = value[msd_pkg::CFG_W-1:0];
                msd_pkg::REG_DAMPING:  damping  = value[msd_pkg::CFG_W-1:0];
                msd_pkg::REG_INIT_POS: init_pos = $signed(value[msd_pkg::INIT_W-1:0]);
                msd_pkg::REG_INIT_VEL: init_vel = $signed(value[msd_pkg::INIT_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint clip_word(longint v);
            if (v > WORD_HI) begin
                clipped = 1'b1;
                return WORD_HI;
            end
            if (v < WORD_LO) begin
                clipped = 1'b1;
                return WORD_LO;
            end
            return v;
        endfunction

        // Give a magnitude its sign. The most negative word is reachable
        // without a clip, one step further is not.
        function longint apply_sign(logic [63:0] m, bit neg, bit over);
            if (neg) begin
                if (over || m > 64'h8000_0000) begin
                    clipped = 1'b1;
                    return WORD_LO;
                end
                return -longint'(m);
            end
            if (over || m > 64'h7FFF_FFFF) begin
                clipped = 1'b1;
                return WORD_HI;
            end
            return longint'(m);
        endfunction

        // Exact product, scaled down with truncation toward zero. The time
        // difference can be one bit wider than a word, so the product is
        // formed at 128 bits.
        function longint scaled_mul(longint a, longint b);
            logic [63:0]  ua, ub;
            logic [127:0] p;
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            p  = {64'd0, ua} * {64'd0, ub};
            p  = p >> msd_pkg::FRAC_W;
            return apply_sign(p[63:0], (a < 0) != (b < 0), p[127:64] != 0);
        endfunction

        function longint scaled_div(longint n, logic [msd_pkg::CFG_W-1:0] d);
            logic [63:0] un, q;
            un = (n < 0) ? -n : n;
            q  = (un << msd_pkg::FRAC_W) / 64'(d);
            return apply_sign(q, n < 0, 1'b0);
        endfunction

        function longint mean_floor(longint a, longint b);
            return (a + b) >>> 1;
        endfunction

        function void note_item(logic cmd, logic [msd_pkg::WORD_W-1:0] force_w,
                                logic [msd_pkg::WORD_W-1:0] t);
            longint                    f, num, acc, dt;
            logic [msd_pkg::CFG_W-1:0] m;
            t_step                     s;
            clipped = 1'b0;
            if (cmd) begin
                pos      = init_pos;
                vel      = init_vel;
                prev_acc = 0;
                prev_vel = 0;
                prev_t   = '0;
            end
            f = $signed(force_w);
            m = (mass != 0) ? mass : msd_pkg::CFG_W'(1);

            num = clip_word(f - scaled_mul(longint'(damping), vel));
            num = clip_word(num - scaled_mul(longint'(spring), pos));
            acc = scaled_div(num, m);

            dt       = longint'(t) - longint'(prev_t);
            vel      = clip_word(vel + scaled_mul(dt, mean_floor(prev_acc, acc)));
            prev_acc = acc;
            pos      = clip_word(pos + scaled_mul(dt, mean_floor(prev_vel, vel)));
            prev_vel = vel;
            prev_t   = t;

            s.position     = pos[msd_pkg::WORD_W-1:0];
            s.velocity     = vel[msd_pkg::WORD_W-1:0];
            s.acceleration = acc[msd_pkg::WORD_W-1:0];
            s.saturated    = clipped;
            expected_q.insert(expected_q.size(), s);
        endfunction

        function void compare_field(string name, logic [msd_pkg::WORD_W-1:0] want,
                                    logic [msd_pkg::WORD_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
                n_errors++;
            end
        endfunction

        function void check_result(logic [msd_pkg::WORD_W-1:0] p,
                                   logic [msd_pkg::WORD_W-1:0] v,
                                   logic [msd_pkg::WORD_W-1:0] a, logic s);
            t_step e;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: position %0d", $signed(p));
                n_errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("position", e.position, p);
            compare_field("velocity", e.velocity, v);
            compare_field("acceleration", e.acceleration, a);
            compare_field("saturated", {31'd0, e.saturated}, {31'd0, s});
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #4 clk = ~clk;

    msd_in_if  in_ch ();
    msd_out_if out_ch ();
    msd_cfg_if cfg_ch ();

    mass_spring_damper_step dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (in_ch),
        .o_result (out_ch),
        .i_cfg    (cfg_ch)
    );

    msd_scoreboard sb = new();

    // When steady is set, neither side inserts idle cycles.
    bit          steady;
    // Input side pacing: the gap before the next word, whether to let the
    // block drain first, and whether valid is still up from the last word.
    int unsigned hold_gap;
    bit          hold_drain;
    bit          held;

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic wait_drained();
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    // Send one input word. Valid stays up into the next word only when that
    // word follows without a gap, so the block never sees a stale word twice.
    task automatic send_item(logic cmd, logic [msd_pkg::WORD_W-1:0] force_w,
                             logic [msd_pkg::WORD_W-1:0] t);
        if (hold_drain) wait_drained();
        repeat (hold_gap) @(posedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.force_req   <= force_w;
        in_ch.sample_time <= t;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_item(cmd, force_w, t);

        hold_drain = !steady && ($urandom_range(0, 39) == 0);
        hold_gap   = draw_gap();
        held       = !hold_drain && hold_gap == 0;
        if (!held) in_ch.valid <= 1'b0;
    endtask

    task automatic stop_items();
        if (held) begin
            in_ch.valid <= 1'b0;
            held = 1'b0;
        end
    endtask

    task automatic write_reg(logic [msd_pkg::IDX_W-1:0] idx,
                             logic [msd_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, value);
    endtask

    // Rewrite all five parameters once the block has nothing in flight.
    task automatic load_params(int unsigned m, int unsigned k, int unsigned c,
                               int p0, int v0);
        stop_items();
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(msd_pkg::REG_MASS, m);
        write_reg(msd_pkg::REG_SPRING, k);
        write_reg(msd_pkg::REG_DAMPING, c);
        write_reg(msd_pkg::REG_INIT_POS, p0);
        write_reg(msd_pkg::REG_INIT_VEL, v0);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [msd_pkg::WORD_W-1:0] rand_force(int unsigned span);
        longint f;
        f = longint'($urandom_range(0, 2 * span)) - longint'(span);
        return f[msd_pkg::WORD_W-1:0];
    endfunction

    // Random stimulus. Most of it is trajectories: a restart at a small time
    // followed by steps whose time mostly moves forward by up to 0.2 s. The
    // rest is noise with every field drawn over its full range.
    task automatic random_run(int n);
        int                         sent, len, k;
        int unsigned                span;
        logic [msd_pkg::WORD_W-1:0] t;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 4) != 0) begin
                len = $urandom_range(3, 30);
                case ($urandom_range(0, 2))
                    0:       span = 32'h0008_0000;
                    1:       span = 32'h0200_0000;
                    default: span = 32'h4000_0000;
                endcase
                t = $urandom_range(0, 6553);
                for (k = 0; k < len && sent < n; k++) begin
                    send_item(k == 0, rand_force(span), t);
                    if ($urandom_range(0, 19) == 0)
                        t = t - $urandom_range(0, 6553);
                    else
                        t = t + $urandom_range(0, 13107);
                    sent++;
                end
            end else begin
                send_item(1'($urandom_range(0, 1)), $urandom, $urandom);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready drops at random before a word is taken, and every
    // word taken is checked against the oldest prediction.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned gap;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = draw_gap();
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            sb.check_result(out_ch.position, out_ch.velocity, out_ch.acceleration,
                            out_ch.saturated);
        end
    end

    // A hung handshake ends the run here.
    initial begin
        #4_500_000;
        $display("** mass_spring_damper_step: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int ph;
        steady     = 1'b0;
        hold_gap   = 0;
        hold_drain = 1'b0;
        held       = 1'b0;

        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= 1'b0;
        in_ch.force_req   <= '0;
        in_ch.sample_time <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= msd_pkg::REG_MASS;
        cfg_ch.data       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default parameters: restart at time zero, then both force extremes,
        // time running backwards, the largest time and a wrap back to zero.
        send_item(1'b1, 32'h0000_0000, 32'h0000_0000);
        send_item(1'b0, 32'h7FFF_FFFF, 32'h0001_0000);
        send_item(1'b0, 32'h8000_0000, 32'h0002_0000);
        send_item(1'b0, 32'h0001_0000, 32'h0000_8000);
        send_item(1'b0, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(1'b1, 32'h0001_0000, 32'h0000_028F);
        send_item(1'b0, 32'hFFFF_0000, 32'h0000_051E);

        // A zero mass acts as the smallest one; stiff spring, no damping and
        // the most negative start position with the largest start velocity.
        load_params(0, 32'h007F_FFFF, 0, -(1 << 20), (1 << 20) - 1);
        send_item(1'b1, 32'h7FFF_FFFF, 32'h0000_0001);
        send_item(1'b0, 32'h8000_0000, 32'h0000_0002);
        send_item(1'b0, 32'h0000_0000, 32'h0001_0000);
        send_item(1'b0, 32'h0000_1000, 32'h0001_0100);

        // The heaviest mass, no spring, full damping, opposite start values.
        load_params(32'h007F_FFFF, 0, 32'h007F_FFFF, (1 << 20) - 1, -(1 << 20));
        send_item(1'b1, 32'h0000_0000, 32'h0001_0000);
        send_item(1'b0, 32'h0001_0000, 32'h0001_8000);
        send_item(1'b0, 32'hFFFF_0000, 32'h0000_4000);
        send_item(1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(1'b0, 32'h8000_0000, 32'hFFFF_0000);

        // Random phases, each under its own parameters. One phase runs with
        // no idle cycles on either side.
        for (ph = 0; ph < 6; ph++) begin
            if (ph == 0)
                load_params(32'(msd_pkg::RST_MASS), 32'(msd_pkg::RST_SPRING),
                            32'(msd_pkg::RST_DAMPING), 0, 0);
            else
                load_params($urandom_range(16384, 6553600), $urandom_range(0, 6553600),
                            $urandom_range(0, 6553600),
                            int'($urandom_range(0, 1310720)) - 655360,
                            int'($urandom_range(0, 1310720)) - 655360);
            steady = (ph == 2);
            random_run(130);
        end
        steady = 1'b0;

        stop_items();
        wait_drained();
        repeat (60) @(posedge clk);
        if (sb.n_errors == 0 && sb.expected_q.size() == 0)
            $display("** mass_spring_damper_step: PASSED **");
        else
            $display("** mass_spring_damper_step: FAILED **");
        $finish;
    end

endmodule
